// ----- sv/o4smu_pkg.sv -----
// shared types and constants for the o4 site metropolis update block
// used by o4smu_mul and o4_site_metropolis_update; no dependencies
package o4smu_pkg;

    localparam int OPND_W = 50;
    localparam int RES_W  = 48;
    localparam int ACC_W  = 100;

    localparam logic [1:0] SH_24 = 2'd0;
    localparam logic [1:0] SH_26 = 2'd1;
    localparam logic [1:0] SH_28 = 2'd2;
    localparam logic [1:0] SH_0  = 2'd3;

    localparam logic [24:0] Q_ONE     = 25'd16777216;
    localparam logic [28:0] LN2_Q24   = 29'd11629080;
    localparam logic [47:0] EXP_LIMIT = 48'd290727000;
    localparam logic [3:0]  EXP_TERMS = 4'd10;

    localparam logic [1:0] OUT_DOWN   = 2'd0;
    localparam logic [1:0] OUT_UP_ACC = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic [1:0]               shsel;
    } mul_req_t;

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111)
        begin
            r = v[47:0];
        end
        else if (v[50])
        begin
            r = {1'b1, 47'd0};
        end
        else
        begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v[48:31] == 18'd0 || v[48:31] == {18{1'b1}})
        begin
            r = v[31:0];
        end
        else if (v[48])
        begin
            r = {1'b1, 31'd0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // floor(2^28 / n) for the series divisors
    function automatic logic [28:0] recip(input logic [3:0] n);
        logic [28:0] r;
        unique case (n)
            4'd1:    r = 29'd268435456;
            4'd2:    r = 29'd134217728;
            4'd3:    r = 29'd89478485;
            4'd4:    r = 29'd67108864;
            4'd5:    r = 29'd53687091;
            4'd6:    r = 29'd44739242;
            4'd7:    r = 29'd38347922;
            4'd8:    r = 29'd33554432;
            4'd9:    r = 29'd29826161;
            4'd10:   r = 29'd26843545;
            default: r = 29'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/o4smu_mul.sv -----
// shared multiplier: floor(a*b / 2^s) saturated to 48 bit signed
// 16 bit digit per cycle over four digits of b, then a scaling step; uses o4smu_pkg
module o4smu_mul
    import o4smu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_req_t                req,
    output logic                    done,
    output logic signed [RES_W-1:0] result
);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [1:0]        cnt_reg;
    logic [OPND_W-1:0] mag_a_reg;
    logic [63:0]       b_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              neg_reg;
    logic [1:0]        sh_reg;
    logic signed [RES_W-1:0] result_reg;

    logic [ACC_W-1:0]  q;
    logic              rem;
    logic              over;
    logic signed [RES_W-1:0] scaled;

    always_comb
    begin
        unique case (sh_reg)
            SH_24:
            begin
                q   = acc_reg >> 24;
                rem = |acc_reg[23:0];
            end
            SH_26:
            begin
                q   = acc_reg >> 26;
                rem = |acc_reg[25:0];
            end
            SH_28:
            begin
                q   = acc_reg >> 28;
                rem = |acc_reg[27:0];
            end
            default:
            begin
                q   = acc_reg;
                rem = 1'b0;
            end
        endcase
        over = |q[ACC_W-1:47];
        if (!neg_reg)
        begin
            scaled = over ? {1'b0, {47{1'b1}}} : q[47:0];
        end
        else
        begin
            scaled = over ? {1'b1, 47'd0} : -(q[47:0] + 48'(rem));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg && !fin_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd3;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg && !fin_reg)
        begin
            mag_a_reg <= req.a[OPND_W-1] ? OPND_W'(-req.a) : OPND_W'(req.a);
            b_reg     <= {14'd0, (req.b[OPND_W-1] ? OPND_W'(-req.b) : OPND_W'(req.b))};
            neg_reg   <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
            sh_reg    <= req.shsel;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[ACC_W-17:0], 16'd0}
                       + ACC_W'({16'd0, mag_a_reg} * {50'd0, b_reg[63:48]});
            b_reg   <= {b_reg[47:0], 16'd0};
        end
        else if (fin_reg)
        begin
            result_reg <= scaled;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/o4_site_metropolis_update.sv -----
// top level of the o4 site metropolis update block: sequencer, state and stream ports
// depends on o4smu_pkg and o4smu_mul
//
// One word per field component enters on the s_ side; the block is busy while it works on it.
// All products go through one shared multiplier. A component needs the six-neighbour sum and
// five products, component 0 two more products for the external field. The last component
// adds three products for the action change; when the change is not negative and below
// EXP_LIMIT, range reduction by ln2 and ten series steps of three products each follow.
// Then the NUM_COMPONENTS result words leave on the m_ side, one per cycle as the sink takes
// them.
module o4_site_metropolis_update
    import o4smu_pkg::*;
#(
    parameter int NUM_COMPONENTS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // neighbour_x_plus, neighbour_x_minus, neighbour_y_plus, neighbour_y_minus,
    // neighbour_z_plus, neighbour_z_minus, old_value, gauss_draw, uniform_draw
    input  logic [279:0] s_tdata,
    // component_index
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_value
    output logic [31:0]  m_tdata,
    // out_index, outcome
    output logic [3:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    localparam logic [1:0] CFG_MASS    = 2'd0;
    localparam logic [1:0] CFG_QUARTIC = 2'd1;
    localparam logic [1:0] CFG_FIELD   = 2'd2;
    localparam logic [1:0] CFG_NOISE   = 2'd3;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HEFF   = 4'd1;
    localparam logic [3:0] ST_ISSUE  = 4'd2;
    localparam logic [3:0] ST_WAIT   = 4'd3;
    localparam logic [3:0] ST_ACC    = 4'd4;
    localparam logic [3:0] ST_DS     = 4'd5;
    localparam logic [3:0] ST_RANGE  = 4'd6;
    localparam logic [3:0] ST_KRED   = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    localparam logic [3:0] P_NOISE  = 4'd0;
    localparam logic [3:0] P_OLDSQ  = 4'd1;
    localparam logic [3:0] P_NEWSQ  = 4'd2;
    localparam logic [3:0] P_ODOT   = 4'd3;
    localparam logic [3:0] P_NDOT   = 4'd4;
    localparam logic [3:0] P_OEXT   = 4'd5;
    localparam logic [3:0] P_NEXT   = 4'd6;
    localparam logic [3:0] P_QUART1 = 4'd7;
    localparam logic [3:0] P_QUART2 = 4'd8;
    localparam logic [3:0] P_MASS   = 4'd9;
    localparam logic [3:0] P_EXPPR  = 4'd10;
    localparam logic [3:0] P_EXPQ   = 4'd11;
    localparam logic [3:0] P_EXPQN  = 4'd12;

    // control state
    logic [3:0]  state_reg;
    logic [3:0]  step_reg;
    logic [2:0]  hcnt_reg;
    logic [3:0]  n_reg;
    logic [4:0]  k_reg;
    logic [AW-1:0] ecnt_reg;
    logic        out_valid_reg;
    logic signed [47:0] osn_reg;
    logic signed [47:0] nsn_reg;
    logic signed [47:0] ofd_reg;
    logic signed [47:0] nfd_reg;
    logic signed [31:0] mass_reg;
    logic [30:0] quartic_reg;
    logic signed [31:0] field_reg;
    logic [30:0] noise_reg;

    // datapath
    logic [1:0]  idx_reg;
    logic signed [31:0] nb_reg [6];
    logic signed [31:0] old_reg;
    logic signed [31:0] gauss_reg;
    logic [23:0] uni_reg;
    logic signed [34:0] heff_reg;
    logic signed [31:0] prop_reg;
    logic signed [48:0] od_reg;
    logic signed [48:0] nd_reg;
    logic signed [47:0] qa_reg;
    logic signed [47:0] quart_reg;
    logic signed [47:0] mt_reg;
    logic signed [47:0] ds_reg;
    logic [28:0] d_reg;
    logic [23:0] t_reg;
    logic [23:0] q0_reg;
    logic [24:0] p_reg;
    logic [1:0]  outcome_reg;
    logic signed [31:0] old_store [NUM_COMPONENTS];
    logic signed [31:0] prop_store [NUM_COMPONENTS];
    logic [31:0] out_data_reg;
    logic [3:0]  out_user_reg;
    logic        out_last_reg;

    mul_req_t    mul_req;
    logic        mul_done;
    logic signed [RES_W-1:0] mul_res;

    logic        in_fire;
    logic        idx_ok;
    logic        is_last;
    logic        ecnt_last;
    logic        emit_go;
    logic signed [48:0] dd;
    logic signed [48:0] dsn;
    logic signed [48:0] ssum;
    logic [24:0] qn_check;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign idx_ok    = 32'(s_tuser) < NUM_COMPONENTS;
    assign is_last   = 32'(idx_reg) == NUM_COMPONENTS - 1;
    assign ecnt_last = 32'(ecnt_reg) == NUM_COMPONENTS - 1;
    assign emit_go   = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign dd   = 49'(nfd_reg) - 49'(ofd_reg);
    assign dsn  = 49'(nsn_reg) - 49'(osn_reg);
    assign ssum = 49'(nsn_reg) + 49'(osn_reg);
    assign qn_check = 25'(t_reg) - 25'(mul_res[23:0]);

    always_comb
    begin
        mul_req.start = (state_reg == ST_ISSUE);
        mul_req.shsel = SH_24;
        unique case (step_reg)
            P_NOISE:
            begin
                mul_req.a = OPND_W'(noise_reg);
                mul_req.b = OPND_W'(gauss_reg);
            end
            P_OLDSQ:
            begin
                mul_req.a = OPND_W'(old_reg);
                mul_req.b = OPND_W'(old_reg);
            end
            P_NEWSQ:
            begin
                mul_req.a = OPND_W'(prop_reg);
                mul_req.b = OPND_W'(prop_reg);
            end
            P_ODOT:
            begin
                mul_req.a = OPND_W'(heff_reg);
                mul_req.b = OPND_W'(old_reg);
            end
            P_NDOT:
            begin
                mul_req.a = OPND_W'(heff_reg);
                mul_req.b = OPND_W'(prop_reg);
            end
            P_OEXT:
            begin
                mul_req.a = OPND_W'(field_reg);
                mul_req.b = OPND_W'(old_reg);
            end
            P_NEXT:
            begin
                mul_req.a = OPND_W'(field_reg);
                mul_req.b = OPND_W'(prop_reg);
            end
            P_QUART1:
            begin
                mul_req.a     = OPND_W'(quartic_reg);
                mul_req.b     = OPND_W'(dsn);
                mul_req.shsel = SH_26;
            end
            P_QUART2:
            begin
                mul_req.a = OPND_W'(qa_reg);
                mul_req.b = OPND_W'(ssum);
            end
            P_MASS:
            begin
                mul_req.a = OPND_W'(mass_reg);
                mul_req.b = OPND_W'(dsn);
            end
            P_EXPPR:
            begin
                mul_req.a = OPND_W'(d_reg[23:0]);
                mul_req.b = OPND_W'(p_reg);
            end
            P_EXPQ:
            begin
                mul_req.a     = OPND_W'(t_reg);
                mul_req.b     = OPND_W'(recip(n_reg));
                mul_req.shsel = SH_28;
            end
            P_EXPQN:
            begin
                mul_req.a     = OPND_W'(q0_reg);
                mul_req.b     = OPND_W'(n_reg);
                mul_req.shsel = SH_0;
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    o4smu_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= P_NOISE;
            hcnt_reg      <= 3'd0;
            n_reg         <= 4'd0;
            k_reg         <= 5'd0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            osn_reg       <= '0;
            nsn_reg       <= '0;
            ofd_reg       <= '0;
            nfd_reg       <= '0;
            mass_reg      <= 32'sd50331648;
            quartic_reg   <= 31'd16777216;
            field_reg     <= '0;
            noise_reg     <= 31'd16777216;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MASS:    mass_reg    <= cfg_data;
                    CFG_QUARTIC: quartic_reg <= cfg_data[30:0];
                    CFG_FIELD:   field_reg   <= cfg_data;
                    CFG_NOISE:   noise_reg   <= cfg_data[30:0];
                    default:     ;
                endcase
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && idx_ok)
                    begin
                        state_reg <= ST_HEFF;
                        hcnt_reg  <= 3'd0;
                    end
                end
                ST_HEFF:
                begin
                    hcnt_reg <= hcnt_reg + 3'd1;
                    if (hcnt_reg == 3'd5)
                    begin
                        state_reg <= ST_ISSUE;
                        step_reg  <= P_NOISE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (step_reg)
                            P_NOISE:
                            begin
                                step_reg  <= P_OLDSQ;
                                state_reg <= ST_ISSUE;
                            end
                            P_OLDSQ:
                            begin
                                osn_reg   <= sat48(51'(osn_reg) + 51'(mul_res));
                                step_reg  <= P_NEWSQ;
                                state_reg <= ST_ISSUE;
                            end
                            P_NEWSQ:
                            begin
                                nsn_reg   <= sat48(51'(nsn_reg) + 51'(mul_res));
                                step_reg  <= P_ODOT;
                                state_reg <= ST_ISSUE;
                            end
                            P_ODOT:
                            begin
                                step_reg  <= P_NDOT;
                                state_reg <= ST_ISSUE;
                            end
                            P_NDOT:
                            begin
                                if (idx_reg == 2'd0)
                                begin
                                    step_reg  <= P_OEXT;
                                    state_reg <= ST_ISSUE;
                                end
                                else
                                begin
                                    state_reg <= ST_ACC;
                                end
                            end
                            P_OEXT:
                            begin
                                step_reg  <= P_NEXT;
                                state_reg <= ST_ISSUE;
                            end
                            P_NEXT:   state_reg <= ST_ACC;
                            P_QUART1:
                            begin
                                step_reg  <= P_QUART2;
                                state_reg <= ST_ISSUE;
                            end
                            P_QUART2:
                            begin
                                step_reg  <= P_MASS;
                                state_reg <= ST_ISSUE;
                            end
                            P_MASS:   state_reg <= ST_DS;
                            P_EXPPR:
                            begin
                                step_reg  <= P_EXPQ;
                                state_reg <= ST_ISSUE;
                            end
                            P_EXPQ:
                            begin
                                step_reg  <= P_EXPQN;
                                state_reg <= ST_ISSUE;
                            end
                            P_EXPQN:
                            begin
                                if (n_reg == 4'd1)
                                begin
                                    state_reg <= ST_DECIDE;
                                end
                                else
                                begin
                                    n_reg     <= n_reg - 4'd1;
                                    step_reg  <= P_EXPPR;
                                    state_reg <= ST_ISSUE;
                                end
                            end
                            default:  state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ACC:
                begin
                    ofd_reg <= sat48(51'(ofd_reg) + 51'(od_reg));
                    nfd_reg <= sat48(51'(nfd_reg) + 51'(nd_reg));
                    if (is_last)
                    begin
                        state_reg <= ST_ISSUE;
                        step_reg  <= P_QUART1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DS:
                begin
                    state_reg <= ST_RANGE;
                end
                ST_RANGE:
                begin
                    if (ds_reg < 0 || ds_reg >= signed'(EXP_LIMIT))
                    begin
                        state_reg <= ST_EMIT;
                        ecnt_reg  <= '0;
                        osn_reg   <= '0;
                        nsn_reg   <= '0;
                        ofd_reg   <= '0;
                        nfd_reg   <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_KRED;
                        k_reg     <= 5'd0;
                    end
                end
                ST_KRED:
                begin
                    if (d_reg >= LN2_Q24)
                    begin
                        k_reg <= k_reg + 5'd1;
                    end
                    else
                    begin
                        n_reg     <= EXP_TERMS;
                        step_reg  <= P_EXPPR;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_DECIDE:
                begin
                    state_reg <= ST_EMIT;
                    ecnt_reg  <= '0;
                    osn_reg   <= '0;
                    nsn_reg   <= '0;
                    ofd_reg   <= '0;
                    nfd_reg   <= '0;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        if (ecnt_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ecnt_reg <= ecnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_reg   <= s_tuser;
                    nb_reg[0] <= s_tdata[31:0];
                    nb_reg[1] <= s_tdata[63:32];
                    nb_reg[2] <= s_tdata[95:64];
                    nb_reg[3] <= s_tdata[127:96];
                    nb_reg[4] <= s_tdata[159:128];
                    nb_reg[5] <= s_tdata[191:160];
                    old_reg   <= s_tdata[223:192];
                    gauss_reg <= s_tdata[255:224];
                    uni_reg   <= s_tdata[279:256];
                    heff_reg  <= '0;
                end
            end
            ST_HEFF:
            begin
                heff_reg <= heff_reg + 35'(nb_reg[hcnt_reg]);
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    unique case (step_reg)
                        P_NOISE:  prop_reg  <= sat32(49'(old_reg) + 49'(mul_res));
                        P_ODOT:   od_reg    <= 49'(mul_res);
                        P_NDOT:   nd_reg    <= 49'(mul_res);
                        P_OEXT:   od_reg    <= od_reg + 49'(mul_res);
                        P_NEXT:   nd_reg    <= nd_reg + 49'(mul_res);
                        P_QUART1: qa_reg    <= mul_res;
                        P_QUART2: quart_reg <= mul_res;
                        P_MASS:   mt_reg    <= mul_res;
                        P_EXPPR:  t_reg     <= mul_res[23:0];
                        P_EXPQ:   q0_reg    <= mul_res[23:0];
                        P_EXPQN:
                        begin
                            if (qn_check >= 25'(n_reg))
                            begin
                                p_reg <= Q_ONE - (25'(q0_reg) + 25'd1);
                            end
                            else
                            begin
                                p_reg <= Q_ONE - 25'(q0_reg);
                            end
                        end
                        default:  ;
                    endcase
                end
            end
            ST_ACC:
            begin
                old_store[AW'(idx_reg)]  <= old_reg;
                prop_store[AW'(idx_reg)] <= prop_reg;
            end
            ST_DS:
            begin
                ds_reg <= sat48(-51'(dd) + 51'(mt_reg) + 51'(quart_reg));
            end
            ST_RANGE:
            begin
                d_reg       <= ds_reg[28:0];
                p_reg       <= Q_ONE;
                outcome_reg <= (ds_reg < 0) ? OUT_DOWN : OUT_REJECT;
            end
            ST_KRED:
            begin
                if (d_reg >= LN2_Q24)
                begin
                    d_reg <= d_reg - LN2_Q24;
                end
            end
            ST_DECIDE:
            begin
                outcome_reg <= (25'(uni_reg) < (p_reg >> k_reg)) ? OUT_UP_ACC : OUT_REJECT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_data_reg <= (outcome_reg == OUT_REJECT) ? old_store[ecnt_reg]
                                                                : prop_store[ecnt_reg];
                    out_user_reg <= {outcome_reg, 2'(ecnt_reg)};
                    out_last_reg <= ecnt_last;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/o4smu_checker.sv -----
// port-level checks for o4_site_metropolis_update, attached by bind
// depends only on the top level's ports and its NUM_COMPONENTS parameter
module o4smu_checker
#(
    parameter int NUM_COMPONENTS = 4
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [279:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic [3:0]   m_tuser,
    input logic         m_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    // a component word in range keeps the block busy for its work
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (32'(s_tuser) < NUM_COMPONENTS) |=> !s_tready)
        else $error("block ready right after accepting a component");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> 32'(m_tuser[1:0]) == NUM_COMPONENTS - 1)
        else $error("site end on wrong component");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[3:2] != 2'd3)
        else $error("undefined outcome code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind o4_site_metropolis_update o4smu_checker #(.NUM_COMPONENTS(NUM_COMPONENTS)) u_o4smu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ----- test/o4_site_metropolis_update_tb.sv -----
// self-checking testbench for o4_site_metropolis_update: directed and random sites with idling
// depends on o4smu_pkg and the o4_site_metropolis_update rtl; predicts results in a scoreboard
module o4_site_metropolis_update_tb
    import o4smu_pkg::*;
();

    localparam int NCOMP = 4;
    localparam logic [1:0] REG_MASS  = 2'd0;
    localparam logic [1:0] REG_QUART = 2'd1;
    localparam logic [1:0] REG_FIELD = 2'd2;
    localparam logic [1:0] REG_NOISE = 2'd3;
    localparam longint LIM_POS = (64'sd1 <<< 47) - 1;
    localparam longint LIM_NEG = -(64'sd1 <<< 47);
    localparam longint LIM32_POS = 64'sd2147483647;
    localparam longint LIM32_NEG = -64'sd2147483648;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] value;
        logic [1:0]  outcome;
        logic        last;
    } site_word_t;

    class site_scoreboard;
        longint mass, quart, field, noise;
        longint old_val [NCOMP];
        longint prop_val [NCOMP];
        longint old_norm, new_norm, old_dot, new_dot;
        site_word_t pending[$];
        int errors;

        function void reset_state();
            mass = 50331648;
            quart = 16777216;
            field = 0;
            noise = 16777216;
            old_norm = 0;
            new_norm = 0;
            old_dot = 0;
            new_dot = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] r, logic [31:0] d);
            case (r)
                REG_MASS:  mass = longint'($signed(d));
                REG_QUART: quart = longint'(d[30:0]);
                REG_FIELD: field = longint'($signed(d));
                REG_NOISE: noise = longint'(d[30:0]);
                default: ;
            endcase
        endfunction

        function longint sat(longint v, longint hi, longint lo);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint prod_floor(longint a, longint b, int sh);
            logic signed [127:0] p;
            p = (128'(signed'(a)) * 128'(signed'(b))) >>> sh;
            if (p > LIM_POS) return LIM_POS;
            if (p < LIM_NEG) return LIM_NEG;
            return longint'(p);
        endfunction

        function longint unsigned exp_neg(longint ds);
            longint unsigned k, r, p;
            k = ds / 11629080;
            if (k >= 25) return 0;
            r = ds - k * 11629080;
            p = 64'd16777216;
            for (int n = 10; n >= 1; n--)
                p = 64'd16777216 - ((r * p) >> 24) / n;
            return p >> k;
        endfunction

        function void note_input(logic [1:0] idx, logic [31:0] nb [6], logic [31:0] oldw,
                                 logic [31:0] gw, logic [23:0] uni);
            longint heff, ov, pv, od, nd, dd, dsn, ssum, ds, q;
            logic [1:0] oc;
            site_word_t w;
            heff = 0;
            for (int i = 0; i < 6; i++) heff += longint'($signed(nb[i]));
            ov = longint'($signed(oldw));
            pv = sat(ov + prod_floor(noise, longint'($signed(gw)), 24), LIM32_POS, LIM32_NEG);
            old_norm = sat(old_norm + prod_floor(ov, ov, 24), LIM_POS, LIM_NEG);
            new_norm = sat(new_norm + prod_floor(pv, pv, 24), LIM_POS, LIM_NEG);
            od = prod_floor(heff, ov, 24);
            nd = prod_floor(heff, pv, 24);
            if (idx == 0)
            begin
                od += prod_floor(field, ov, 24);
                nd += prod_floor(field, pv, 24);
            end
            old_dot = sat(old_dot + od, LIM_POS, LIM_NEG);
            new_dot = sat(new_dot + nd, LIM_POS, LIM_NEG);
            old_val[idx] = ov;
            prop_val[idx] = pv;
            if (idx != NCOMP - 1) return;
            dd = new_dot - old_dot;
            dsn = new_norm - old_norm;
            ssum = new_norm + old_norm;
            q = prod_floor(prod_floor(quart, dsn, 26), ssum, 24);
            ds = sat(-dd + prod_floor(mass, dsn, 24) + q, LIM_POS, LIM_NEG);
            if (ds < 0) oc = OUT_DOWN;
            else if (longint'(uni) < exp_neg(ds)) oc = OUT_UP_ACC;
            else oc = OUT_REJECT;
            for (int i = 0; i < NCOMP; i++)
            begin
                w.idx = 2'(i);
                w.value = (oc == OUT_REJECT) ? old_val[i][31:0] : prop_val[i][31:0];
                w.outcome = oc;
                w.last = (i == NCOMP - 1);
                pending.push_back(w);
            end
            old_norm = 0;
            new_norm = 0;
            old_dot = 0;
            new_dot = 0;
        endfunction

        function void check_result(site_word_t got);
            site_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.idx !== exp_w.idx)
            begin
                $display("%0t out_index: expected %0d, actual %0d", $time, exp_w.idx, got.idx);
                errors++;
            end
            if (got.value !== exp_w.value)
            begin
                $display("%0t new_value: expected %h, actual %h", $time, exp_w.value, got.value);
                errors++;
            end
            if (got.outcome !== exp_w.outcome)
            begin
                $display("%0t outcome: expected %0d, actual %0d", $time, exp_w.outcome,
                         got.outcome);
                errors++;
            end
            if (got.last !== exp_w.last)
            begin
                $display("%0t last_of_site: expected %0d, actual %0d", $time, exp_w.last,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [279:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    site_scoreboard sb;
    int send_idle_pct;
    int sink_stall_pct;
    bit hold_sink;
    int quiet_cycles;

    o4_site_metropolis_update dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tuser[1:0], m_tdata, m_tuser[3:2], m_tlast});
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("o4_site_metropolis_update regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(67108863)) - 33554432);
        endcase
    endfunction

    task automatic send_word(logic [1:0] idx, logic [31:0] nb [6], logic [31:0] oldw,
                             logic [31:0] gw, logic [23:0] uni);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= idx;
        s_tdata <= {uni, gw, oldw, nb[5], nb[4], nb[3], nb[2], nb[1], nb[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (idx < NCOMP)
            sb.note_input(idx, nb, oldw, gw, uni);
    endtask

    task automatic send_site(int mode, bit with_noise);
        logic [31:0] nb [6];
        for (int c = 0; c < NCOMP; c++)
        begin
            if (with_noise && $urandom_range(7) == 0)
            begin
                foreach (nb[i]) nb[i] = $urandom;
                send_word(c[1:0], nb, rand_value(3), rand_value(3), 24'($urandom));
            end
            foreach (nb[i]) nb[i] = rand_value(mode == 0 ? $urandom_range(3) : mode);
            send_word(c[1:0], nb, rand_value(mode == 0 ? $urandom_range(3) : mode),
                      rand_value(mode == 0 ? $urandom_range(3) : mode), 24'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] r, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(r, d);
    endtask

    task automatic write_all(logic [31:0] m, logic [31:0] q, logic [31:0] f, logic [31:0] n);
        write_reg(REG_MASS, m);
        write_reg(REG_QUART, q);
        write_reg(REG_FIELD, f);
        write_reg(REG_NOISE, n);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] nb [6];
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_sink = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, small values, repeated component
        send_site(1, 0);
        send_site(2, 0);
        send_site(3, 0);
        foreach (nb[i]) nb[i] = 32'h01000000;
        send_word(2'd0, nb, 32'h00800000, 32'h0, 24'hffffff);
        send_word(2'd0, nb, 32'hff000000, 32'h00400000, 24'h0);
        send_word(2'd1, nb, 32'h0, 32'h0, 24'h0);
        send_word(2'd2, nb, 32'h0, 32'h0, 24'h0);
        send_word(2'd3, nb, 32'h0, 32'h0, 24'h0);
        send_site(0, 0);
        drain();

        write_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_site(0, 0);
        send_site(3, 0);
        drain();
        write_all(32'h7fffffff, 32'h0, 32'h80000000, 32'h0);
        send_site(3, 0);
        send_site(2, 0);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 27) : 0;
            sink_stall_pct = (ph == 2) ? 46 : (ph == 3 ? 27 : 0);
            write_all($urandom, $urandom_range(33554432), $urandom_range(67108863) - 33554432,
                      $urandom_range(16777216));
            for (int s = 0; s < 20; s++)
                send_site($urandom_range(3) == 0 ? 2 : 3, 1);
            drain();
        end

        // sink held off long while the sender keeps offering
        send_idle_pct = 0;
        sink_stall_pct = 0;
        fork
            begin
                hold_sink = 1'b1;
                repeat (2000) @(posedge clk);
                hold_sink = 1'b0;
            end
            begin
                for (int s = 0; s < 4; s++)
                    send_site(3, 0);
            end
        join
        drain();
        write_all(32'd50331648, 32'd16777216, 32'd0, 32'd16777216);
        for (int s = 0; s < 6; s++)
            send_site(3, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("o4_site_metropolis_update regression: pass");
        else
            $display("o4_site_metropolis_update regression: fail");
        $finish;
    end
endmodule
